@@ design/alfd_pkg.sv @@
// Shared types and constants for the ASCII length-framed deframer.
package alfd_pkg;

  // Receive characters
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Result status codes
  localparam logic [2:0] ST_DATA        = 3'd0;
  localparam logic [2:0] ST_OK          = 3'd1;
  localparam logic [2:0] ST_BAD_MARKER  = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd3;
  localparam logic [2:0] ST_BAD_TRAILER = 3'd4;

  // Field widths
  localparam int unsigned ACC_W = 14;
  localparam int unsigned ID_W  = 15;
  localparam int unsigned LEN_W = 11;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // One classified byte
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic       is_blank;
    logic       is_plus;
    logic       is_minus;
    logic       is_pct;
    logic       is_hash;
  } class_t;

  typedef enum logic [6:0] {
    S_MARK0   = 7'b0000001,
    S_MARK1   = 7'b0000010,
    S_ID      = 7'b0000100,
    S_LEN     = 7'b0001000,
    S_PAYLOAD = 7'b0010000,
    S_TRL0    = 7'b0100000,
    S_TRL1    = 7'b1000000
  } state_t;

endpackage

@@ design/alfd_front.sv @@
// Front end: classifies received bytes and queues them for the sequencer.
module alfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              head_valid,
  output alfd_pkg::class_t  head,
  input  logic              head_pop
);

  alfd_pkg::class_t               queue [alfd_pkg::Q_DEPTH];
  logic [alfd_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [alfd_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [alfd_pkg::Q_CNT_W-1:0]   count;
  alfd_pkg::class_t               cls;
  logic                           push;
  logic                           pop;

  always_comb begin
    cls          = '0;
    cls.data     = rx_byte;
    cls.is_digit = (rx_byte >= alfd_pkg::CH_ZERO) && (rx_byte <= alfd_pkg::CH_NINE);
    cls.is_blank = (rx_byte == alfd_pkg::CH_SPACE) ||
                   ((rx_byte >= alfd_pkg::CH_TAB) && (rx_byte <= alfd_pkg::CH_CR));
    cls.is_plus  = (rx_byte == alfd_pkg::CH_PLUS);
    cls.is_minus = (rx_byte == alfd_pkg::CH_MINUS);
    cls.is_pct   = (rx_byte == alfd_pkg::CH_PCT);
    cls.is_hash  = (rx_byte == alfd_pkg::CH_HASH);
  end

  assign in_ready   = (count != alfd_pkg::Q_CNT_W'(alfd_pkg::Q_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign pop        = head_pop && head_valid;
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/alfd_back.sv @@
// Back end: frame sequencer, atoi-style field parser and output register.
module alfd_back #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  alfd_pkg::class_t               head,
  output logic                           head_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic [7:0]                     data_byte,
  output logic signed [alfd_pkg::ID_W-1:0] frame_id,
  output logic [alfd_pkg::LEN_W-1:0]     frame_length,
  output logic                           last
);

  localparam int unsigned AW = alfd_pkg::ACC_W;

  alfd_pkg::state_t   state, state_next;
  logic [1:0]         fpos, fpos_next;
  logic [AW-1:0]      id_acc, id_acc_next;
  logic [AW-1:0]      len_acc, len_acc_next;
  logic [AW-1:0]      count, count_next;
  logic [alfd_pkg::ID_W-1:0] held_id, held_id_next;
  logic               negative, negative_next;
  logic               started, started_next;
  logic               stopped, stopped_next;
  logic               marker_bad, marker_bad_next;

  logic               emit;
  logic [2:0]         emit_status;
  logic [7:0]         emit_data;
  logic [alfd_pkg::ID_W-1:0]  emit_id;
  logic [alfd_pkg::LEN_W-1:0] emit_len;

  // parser datapath
  logic [AW-1:0] acc_cur, acc_x10, acc_upd, acc_new;
  logic          p_neg, p_started, p_stopped;
  logic [alfd_pkg::ID_W-1:0] id_ext;
  logic [AW-1:0] cnt_inc;
  logic          len_bad;

  assign head_pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    acc_cur   = (state == alfd_pkg::S_ID) ? id_acc : len_acc;
    acc_x10   = {acc_cur[AW-4:0], 3'b000} + {acc_cur[AW-2:0], 1'b0};
    acc_upd   = acc_x10 + {{(AW-4){1'b0}}, head.data[3:0]};
    acc_new   = acc_cur;
    p_neg     = negative;
    p_started = started;
    p_stopped = stopped;
    if (!stopped) begin
      if (!started) begin
        if (head.is_blank) begin
          p_started = 1'b0;
        end else if (head.is_plus || head.is_minus) begin
          p_started = 1'b1;
          p_neg     = head.is_minus;
        end else if (head.is_digit) begin
          p_started = 1'b1;
          acc_new   = {{(AW-4){1'b0}}, head.data[3:0]};
        end else begin
          p_stopped = 1'b1;
        end
      end else if (head.is_digit) begin
        acc_new = acc_upd;
      end else begin
        p_stopped = 1'b1;
      end
    end
    id_ext  = {1'b0, acc_new};
    cnt_inc = count + 1'b1;
    len_bad = (p_neg && (acc_new != '0)) || (acc_new > AW'(MAX_PAYLOAD));
  end

  always_comb begin
    state_next      = state;
    fpos_next       = fpos;
    id_acc_next     = id_acc;
    len_acc_next    = len_acc;
    count_next      = count;
    held_id_next    = held_id;
    negative_next   = negative;
    started_next    = started;
    stopped_next    = stopped;
    marker_bad_next = marker_bad;
    emit            = 1'b0;
    emit_status     = alfd_pkg::ST_DATA;
    emit_data       = '0;
    emit_id         = '0;
    emit_len        = '0;
    unique case (state)
      alfd_pkg::S_MARK0: begin
        marker_bad_next = !head.is_pct;
        id_acc_next     = '0;
        len_acc_next    = '0;
        count_next      = '0;
        held_id_next    = '0;
        fpos_next       = '0;
        negative_next   = 1'b0;
        started_next    = 1'b0;
        stopped_next    = 1'b0;
        state_next      = alfd_pkg::S_MARK1;
      end
      alfd_pkg::S_MARK1: begin
        if (!head.is_hash) marker_bad_next = 1'b1;
        fpos_next     = '0;
        negative_next = 1'b0;
        started_next  = 1'b0;
        stopped_next  = 1'b0;
        state_next    = alfd_pkg::S_ID;
      end
      alfd_pkg::S_ID: begin
        id_acc_next   = acc_new;
        negative_next = p_neg;
        started_next  = p_started;
        stopped_next  = p_stopped;
        if (fpos != 2'd3) begin
          fpos_next = fpos + 1'b1;
        end else begin
          held_id_next  = p_neg ? (alfd_pkg::ID_W'(0) - id_ext) : id_ext;
          fpos_next     = '0;
          negative_next = 1'b0;
          started_next  = 1'b0;
          stopped_next  = 1'b0;
          state_next    = alfd_pkg::S_LEN;
        end
      end
      alfd_pkg::S_LEN: begin
        len_acc_next  = acc_new;
        negative_next = p_neg;
        started_next  = p_started;
        stopped_next  = p_stopped;
        if (fpos != 2'd3) begin
          fpos_next = fpos + 1'b1;
        end else if (marker_bad) begin
          emit        = 1'b1;
          emit_status = alfd_pkg::ST_BAD_MARKER;
          state_next  = alfd_pkg::S_MARK0;
        end else if (len_bad) begin
          emit        = 1'b1;
          emit_status = alfd_pkg::ST_BAD_LENGTH;
          state_next  = alfd_pkg::S_MARK0;
        end else begin
          count_next = '0;
          state_next = (acc_new == '0) ? alfd_pkg::S_TRL0 : alfd_pkg::S_PAYLOAD;
        end
      end
      alfd_pkg::S_PAYLOAD: begin
        emit        = 1'b1;
        emit_status = alfd_pkg::ST_DATA;
        emit_data   = head.data;
        count_next  = cnt_inc;
        if (cnt_inc >= len_acc) state_next = alfd_pkg::S_TRL0;
      end
      alfd_pkg::S_TRL0: begin
        marker_bad_next = !head.is_pct;
        state_next      = alfd_pkg::S_TRL1;
      end
      alfd_pkg::S_TRL1: begin
        emit       = 1'b1;
        state_next = alfd_pkg::S_MARK0;
        if (marker_bad || !head.is_hash) begin
          marker_bad_next = 1'b1;
          emit_status     = alfd_pkg::ST_BAD_TRAILER;
        end else begin
          emit_status = alfd_pkg::ST_OK;
          emit_id     = held_id;
          emit_len    = len_acc[alfd_pkg::LEN_W-1:0];
        end
      end
      default: begin
        state_next = alfd_pkg::S_MARK0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= alfd_pkg::S_MARK0;
      fpos       <= '0;
      id_acc     <= '0;
      len_acc    <= '0;
      count      <= '0;
      held_id    <= '0;
      negative   <= 1'b0;
      started    <= 1'b0;
      stopped    <= 1'b0;
      marker_bad <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (head_pop) begin
        state      <= state_next;
        fpos       <= fpos_next;
        id_acc     <= id_acc_next;
        len_acc    <= len_acc_next;
        count      <= count_next;
        held_id    <= held_id_next;
        negative   <= negative_next;
        started    <= started_next;
        stopped    <= stopped_next;
        marker_bad <= marker_bad_next;
      end
      if (head_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop && emit) begin
      status       <= emit_status;
      data_byte    <= emit_data;
      frame_id     <= emit_id;
      frame_length <= emit_len;
      last         <= (emit_status != alfd_pkg::ST_DATA);
    end
  end

endmodule

@@ design/ascii_length_frame_deframer.sv @@
// Top level of the ASCII length-framed deframer.
//
// Input channel (in_valid/in_ready/rx_byte): one received byte per request.
// Frame: "%#", 4-char decimal id, 4-char decimal length, payload, "%#".
// Id and length are parsed atoi-style (blanks, optional sign, digits).
// Output channel (out_valid/out_ready): at most one result per byte.
//   status 0 carries a payload byte in data_byte; status 1 ends a good
//   frame with frame_id and frame_length; status 2/3/4 report a bad header
//   marker, bad length or bad trailer. last marks the frame-ending result.
// Header bytes (bar a header error) and the first trailer byte emit nothing.
// Throughput: one byte per cycle while out_ready stays high. The front
//   classifies bytes into a 2-entry queue; the back sequencer drains one
//   entry per cycle, loading any result into the output register.
// Path: an accepted byte is written into the queue; when the sequencer pops
//   it, any result it yields is loaded into the output register.
// Stall: while out_ready is low with a result pending, the output register
//   holds it, the sequencer stops, the queue fills and in_ready drops at two.
// Reset (rst, synchronous): queue empty, no result pending, sequencer waits
//   for the first marker byte of a header.
// After any error the block waits for a new header; no resync on "%#".
module ascii_length_frame_deframer #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              status,
  output logic [7:0]              data_byte,
  output logic signed [14:0]      frame_id,
  output logic [10:0]             frame_length,
  output logic                    last
);

  logic             head_valid;
  logic             head_pop;
  alfd_pkg::class_t head;

  // Byte classifier and request queue
  alfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // Frame sequencer with result register
  alfd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .data_byte    (data_byte),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .last         (last)
  );

endmodule

@@ design/alfd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
module alfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [7:0]  data_byte,
  input logic [14:0] frame_id,
  input logic [10:0] frame_length,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_byte) &&
      $stable(frame_id) && $stable(frame_length) && $stable(last))
    else $error("result changed while stalled");

  a_last_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (status != alfd_pkg::ST_DATA)))
    else $error("last does not match status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= alfd_pkg::ST_BAD_TRAILER))
    else $error("status out of range");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != alfd_pkg::ST_OK) |-> (frame_id == '0) && (frame_length == '0) &&
      ((status == alfd_pkg::ST_DATA) || (data_byte == '0)))
    else $error("unused result fields not zero");

endmodule

bind ascii_length_frame_deframer alfd_checker u_alfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .data_byte    (data_byte),
  .frame_id     (frame_id),
  .frame_length (frame_length),
  .last         (last)
);
